### sv/cg_pkg.sv
// shared types and constants for the top-two confidence gate
// no dependencies
`default_nettype none

package cg_pkg;

  localparam int unsigned LogitW  = 16;
  localparam int unsigned MinGapW = 17;
  localparam int unsigned MaxItems = 262144;
  localparam int unsigned PosW    = $clog2(MaxItems);
  localparam logic [PosW-1:0] MaxPos = PosW'(MaxItems - 1);
  localparam logic [LogitW-1:0] GapAllOnes = '1;

  typedef struct packed {
    logic signed [LogitW-1:0] logit;
    logic                     last;
  } cg_item_t;

  // input stage to scan stage
  typedef struct packed {
    logic     valid;
    cg_item_t item;
  } cg_stage_t;

  typedef struct packed {
    logic              accepted;
    logic [PosW-1:0]   winner_index;
    logic [LogitW-1:0] top_gap;
  } cg_result_t;

endpackage

`default_nettype wire

### sv/cg_in_stage.sv
// input register of the confidence gate: holds one accepted logit
// depends on cg_pkg
`default_nettype none

module cg_in_stage import cg_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cg_item_t  item_i,
  input  wire logic      take_i,
  output cg_stage_t      stage_o
);

  logic     valid_q, valid_d;
  cg_item_t item_q;

  // the slot refills in the same cycle its item moves on
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

`default_nettype wire

### sv/cg_scan.sv
// running top-two scan, gap compare and result register
// depends on cg_pkg
`default_nettype none

module cg_scan import cg_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cg_stage_t                 stage_i,
  input  wire logic signed [MinGapW-1:0] min_gap_i,
  output logic                           take_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output cg_result_t                     result_o
);

  logic signed [LogitW-1:0] best_q, best_d;
  logic signed [LogitW-1:0] run_q, run_d;
  logic                     run_valid_q, run_valid_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [PosW-1:0]          seen_q, seen_d;
  logic                     out_valid_q, out_valid_d;
  cg_result_t               result_q, result_d;

  logic signed [LogitW-1:0] v;
  logic                     finish;
  logic signed [LogitW:0]   diff;
  logic                     out_free;

  assign v        = stage_i.item.logit;
  assign out_free = !out_valid_q || out_ready_i;
  // items without the flag never wait on the result register
  assign take_o   = stage_i.valid && (!stage_i.item.last || out_free);
  assign finish   = take_o && stage_i.item.last;

  always_comb begin
    best_d      = best_q;
    run_d       = run_q;
    run_valid_d = run_valid_q;
    pos_d       = pos_q;
    if (seen_q == '0) begin
      best_d = v;
      pos_d  = seen_q;
    end else if (v > best_q) begin
      run_d       = best_q;
      run_valid_d = 1'b1;
      best_d      = v;
      pos_d       = seen_q;
    end else if (!run_valid_q || v > run_q) begin
      run_d       = v;
      run_valid_d = 1'b1;
    end
    seen_d = (seen_q == MaxPos) ? seen_q : seen_q + PosW'(1);
  end

  // best never falls below the runner-up, so the difference is non-negative
  assign diff = {best_d[LogitW-1], best_d} - {run_d[LogitW-1], run_d};

  always_comb begin
    result_d.winner_index = pos_d;
    if (run_valid_d) begin
      result_d.top_gap  = diff[LogitW-1:0];
      result_d.accepted = $signed({1'b0, diff[LogitW-1:0]}) >= min_gap_i;
    end else begin
      result_d.top_gap  = GapAllOnes;
      result_d.accepted = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      run_q       <= '0;
      run_valid_q <= 1'b0;
      pos_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (finish) begin
        best_q      <= '0;
        run_q       <= '0;
        run_valid_q <= 1'b0;
        pos_q       <= '0;
        seen_q      <= '0;
      end else if (take_o) begin
        best_q      <= best_d;
        run_q       <= run_d;
        run_valid_q <= run_valid_d;
        pos_q       <= pos_d;
        seen_q      <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### sv/top2_confidence_gate_top.sv
// top-two confidence gate: in register, running scan, result register
// depends on cg_pkg, cg_in_stage, cg_scan
//
// usage:
//   logits of one vector enter on the in channel (valid/ready), one per
//   transfer, signed Q8.8, with last_logit_i set on the final one.
//   the block keeps best, runner-up and the position of the best value
//   (earliest wins on ties); on the final logit it emits one result on
//   the out channel: accepted_o, winner_index_o and top_gap_o.
//   a single-logit vector gives top_gap_o all ones and is always accepted.
//   min_gap_i is written over the cfg channel (always ready); the user must
//   do so only while idle, which the block itself does not enforce.
// timing: one logit per cycle sustained unless a final logit stalls (below);
//   a result passes the input register, then the result register, with
//   the running compare between the two registers.
// reset:
//   clears the scan state, both valid flags and min_gap to zero.
// stall:
//   while a result waits, logits without the flag keep flowing; a final
//   logit waits in the input register until the result register frees.
`default_nettype none

module top2_confidence_gate_top import cg_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [LogitW-1:0]  logit_value_i,
  input  wire logic                      last_logit_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           accepted_o,
  output logic [PosW-1:0]                winner_index_o,
  output logic [LogitW-1:0]              top_gap_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic signed [MinGapW-1:0] min_gap_i
);

  logic signed [MinGapW-1:0] min_gap_q;
  cg_item_t                  item_in;
  cg_stage_t                 stage;
  cg_result_t                result;
  logic                      take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= '0;
    end else if (cfg_valid_i) begin
      min_gap_q <= min_gap_i;
    end
  end

  assign item_in.logit = logit_value_i;
  assign item_in.last  = last_logit_i;

  cg_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (take),
    .stage_o    (stage)
  );

  cg_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .min_gap_i   (min_gap_q),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign accepted_o     = result.accepted;
  assign winner_index_o = result.winner_index;
  assign top_gap_o      = result.top_gap;

endmodule

`default_nettype wire

### sv/cg_checker.sv
// port-level checks for the confidence gate, bound to the top level
// depends on cg_pkg and top2_confidence_gate_top
`default_nettype none

module cg_checker import cg_pkg::*; (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      last_logit_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic                      accepted_o,
  input wire logic [PosW-1:0]           winner_index_o,
  input wire logic [LogitW-1:0]         top_gap_o,
  input wire logic                      cfg_valid_i,
  input wire logic                      cfg_ready_o
);

  // a rising result valid must trace back to an earlier final logit's transfer
  a_rise_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_logit_i, 2))
    else $error("result without a final logit two cycles before");

  // a full-range gap can never fall short of any minimum
  a_max_gap_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (top_gap_o == GapAllOnes) |-> accepted_o)
    else $error("all-ones gap not accepted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(winner_index_o)
      && $stable(top_gap_o) && $stable(accepted_o))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config transfer refused");

endmodule

bind top2_confidence_gate_top cg_checker u_cg_checker (.*);

`default_nettype wire

### test/top2_confidence_gate_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for top2_confidence_gate_top: queued logit driver,
// clocked result monitor, scoreboard fed by a running top-two predictor
// depends on cg_pkg and top2_confidence_gate_top

module top2_confidence_gate_top_tb;
  import cg_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [LogitW-1:0]  logit_value = '0;
  logic                      last_logit = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      accepted;
  logic [PosW-1:0]           winner_index;
  logic [LogitW-1:0]         top_gap;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic signed [MinGapW-1:0] min_gap_cfg = '0;

  top2_confidence_gate_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .logit_value_i  (logit_value),
    .last_logit_i   (last_logit),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .accepted_o     (accepted),
    .winner_index_o (winner_index),
    .top_gap_o      (top_gap),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .min_gap_i      (min_gap_cfg)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  cg_item_t   logit_q[$];
  cg_result_t verdict_q[$];
  int         mismatch_count = 0;

  // pacing knobs, changed only between phases
  int send_gap_max = 11;
  int recv_gap_max = 11;
  int hold_requests = 0;
  int holds_done = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;

  // running top-two scan state
  logic signed [LogitW-1:0]  best_logit = '0;
  logic [PosW-1:0]           best_at = '0;
  logic signed [LogitW-1:0]  runner_logit = '0;
  logic                      runner_seen = 1'b0;
  logic [PosW-1:0]           logit_count = '0;
  logic signed [MinGapW-1:0] pred_min_gap = '0;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  task automatic scan_logit(input logic signed [LogitW-1:0] v, input logic last);
    int         diff;
    cg_result_t res;
    if (logit_count == '0) begin
      best_logit = v;
      best_at    = logit_count;
    end else if (v > best_logit) begin
      runner_logit = best_logit;
      runner_seen  = 1'b1;
      best_logit   = v;
      best_at      = logit_count;
    end else if (!runner_seen || v > runner_logit) begin
      runner_logit = v;
      runner_seen  = 1'b1;
    end
    // position counter sticks at the top index
    if (logit_count != MaxPos) logit_count++;
    if (last) begin
      res.winner_index = best_at;
      if (runner_seen) begin
        diff         = int'(best_logit) - int'(runner_logit);
        res.top_gap  = diff[LogitW-1:0];
        res.accepted = (diff >= int'(pred_min_gap));
      end else begin
        res.top_gap  = GapAllOnes;
        res.accepted = 1'b1;
      end
      verdict_q.push_back(res);
      best_logit   = '0;
      best_at      = '0;
      runner_logit = '0;
      runner_seen  = 1'b0;
      logit_count  = '0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    cg_item_t nxt;
    logic     offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        scan_logit(logit_value, last_logit);
        offering  = 1'b0;
        send_wait = $urandom_range(send_gap_max, 0);
      end
      if (!offering) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (logit_q.size() != 0) begin
          nxt = logit_q.pop_front();
          logit_value <= nxt.logit;
          last_logit  <= nxt.last;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and ready pacing
  always @(posedge clk) begin
    cg_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          want = verdict_q.pop_front();
          if (accepted !== want.accepted)
            flag_mismatch($sformatf("accepted got %0b want %0b", accepted, want.accepted));
          if (winner_index !== want.winner_index)
            flag_mismatch($sformatf("winner_index got %0d want %0d",
                                    winner_index, want.winner_index));
          if (top_gap !== want.top_gap)
            flag_mismatch($sformatf("top_gap got %h want %h", top_gap, want.top_gap));
        end
        recv_wait = $urandom_range(recv_gap_max, 0);
      end
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_logit(input int v, input bit last);
    cg_item_t it;
    it.logit = LogitW'(v);
    it.last  = last;
    logit_q.push_back(it);
  endtask

  // narrow values crowd into a few levels so ties and zero gaps are common
  task automatic push_vector(input int len, input bit narrow);
    for (int i = 0; i < len; i++) begin
      if (narrow) push_logit(int'($urandom_range(0, 6)) - 3, i == len - 1);
      else push_logit(int'($urandom), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    // sample away from the active edge so the driver's updates have landed
    while (logit_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    // let the input and result registers settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_gap(input logic signed [MinGapW-1:0] value);
    @(posedge clk);
    cfg_valid   <= 1'b1;
    min_gap_cfg <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    pred_min_gap = value;
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 11;
    endcase
  endfunction

  initial begin
    int pushed;
    int len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // min_gap still at its reset value of zero
    push_logit(32767, 1);
    push_logit(-32768, 1);
    push_logit(-32768, 0); push_logit(32767, 1);
    push_logit(32767, 0);  push_logit(-32768, 1);
    push_logit(5, 0);      push_logit(5, 0);      push_logit(5, 1);
    push_logit(-1, 0);     push_logit(3, 0);      push_logit(3, 0);  push_logit(2, 1);
    push_logit(0, 0);      push_logit(256, 0);    push_logit(255, 1);
    wait_drained();

    write_min_gap(1);
    push_logit(7, 0);  push_logit(7, 1);
    push_logit(10, 0); push_logit(9, 1);
    push_logit(-7, 1);
    wait_drained();

    write_min_gap(65535);
    push_logit(32767, 0); push_logit(-32768, 1);
    push_logit(32767, 0); push_logit(-32767, 1);
    push_logit(0, 1);
    wait_drained();

    // negative minimum gap takes every vector
    write_min_gap(-65536);
    push_logit(3, 0); push_logit(3, 1);
    push_logit(-20, 0); push_logit(100, 0); push_logit(99, 1);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: write_min_gap(17'($urandom));
        1: write_min_gap(17'($urandom_range(0, 512)));
        default: write_min_gap(17'($urandom_range(0, 65535)));
      endcase
      send_gap_max = pick_gap_max();
      recv_gap_max = pick_gap_max();
      @(negedge clk);
      if (ph == 2) begin
        // long receiver stall against a full-rate sender
        send_gap_max = 0;
        hold_requests++;
      end
      pushed = 0;
      while (pushed < 200) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        push_vector(len, $urandom_range(0, 2) == 0);
        pushed += len;
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
sv/cg_pkg.sv
sv/cg_in_stage.sv
sv/cg_scan.sv
sv/top2_confidence_gate_top.sv
sv/cg_checker.sv
test/top2_confidence_gate_top_tb.sv
